@@ src/pbs_pkg.sv @@
`timescale 1ns / 1ps
package pbs_pkg;

   // field and register widths
   localparam int VALUE_W    = 32;
   localparam int ROW_W      = 8;
   localparam int COL_W      = 9;
   localparam int ULIM_W     = 25;
   localparam int INV_W      = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   // datapath widths
   localparam int WGT_W   = 17;
   localparam int DIFF_W  = 27;
   localparam int TU_W    = 59;
   localparam int KU_W    = TU_W - 32;
   localparam int TX_W    = 64;
   localparam int BLEND_W = 50;
   localparam int ACC_W   = 66;
   localparam int RND_W   = ACC_W - 32;

   localparam logic [WGT_W-1:0] ONE_Q16    = 17'h1_0000;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'h8000_0000);
   localparam logic signed [RND_W-1:0] RES_MAX = RND_W'($signed(32'h7FFF_FFFF));
   localparam logic signed [RND_W-1:0] RES_MIN = RND_W'($signed(32'h8000_0000));

   // beat kind
   localparam logic MODE_SAMPLE = 1'b1;

   // grid banking by row and column parity
   localparam int BANKS     = 4;
   localparam int CORNER_00 = 0;
   localparam int CORNER_10 = 1;
   localparam int CORNER_01 = 2;
   localparam int CORNER_11 = 3;

   // register reset values
   localparam logic signed [ULIM_W-1:0] U_LOW_RST  = -25'sd393216;
   localparam logic signed [ULIM_W-1:0] U_HIGH_RST = 25'sd393216;
   localparam logic [INV_W-1:0]         INV_DX_RST = 31'd667544;
   localparam logic [INV_W-1:0]         INV_DU_RST = 31'd1398101;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_U_LOW,
      CSR_U_HIGH,
      CSR_INV_DX,
      CSR_INV_DU
   } pbs_csr_type;

   typedef struct packed {
      logic valid;
      logic sample;
      logic load_ok;
   } pbs_ctl_type;

   typedef struct packed {
      logic [WGT_W-1:0] fx;
      logic [WGT_W-1:0] fu;
   } pbs_wgt_type;

endpackage

@@ src/pbs_coord.sv @@
`timescale 1ns / 1ps
module pbs_coord #(
   parameter int NX = 128,
   parameter int NU = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic                                in_mode,
   input  logic [pbs_pkg::ROW_W-1:0]           in_row,
   input  logic [pbs_pkg::COL_W-1:0]           in_col,
   input  logic signed [pbs_pkg::VALUE_W-1:0]  in_value,
   input  logic signed [pbs_pkg::VALUE_W-1:0]  in_x,
   input  logic signed [pbs_pkg::VALUE_W-1:0]  in_u,
   input  logic signed [pbs_pkg::ULIM_W-1:0]   u_low,
   input  logic signed [pbs_pkg::ULIM_W-1:0]   u_high,
   input  logic [pbs_pkg::INV_W-1:0]           inv_dx,
   input  logic [pbs_pkg::INV_W-1:0]           inv_du,
   output pbs_pkg::pbs_ctl_type                out_ctl,
   output logic [$clog2(NX+1)-1:0]             out_row,
   output logic [$clog2(NU+1)-1:0]             out_col,
   output logic [pbs_pkg::VALUE_W-1:0]         out_value,
   output pbs_pkg::pbs_wgt_type                out_wgt
);
   import pbs_pkg::*;

   localparam int RW     = $clog2(NX + 1);
   localparam int CW     = $clog2(NU + 1);
   localparam int RRW    = $clog2(2 * NX);
   localparam int STAGES = 7;
   // multiple of NX that lifts any cell index to a non-negative value
   localparam longint XSPAN = (longint'(1) << 30) + longint'(NX) - 1;
   localparam longint XOFFS = (XSPAN / NX) * NX;
   // reciprocal of NX for the modulo
   localparam longint RECIP = (longint'(1) << 32) / NX;
   localparam logic [31:0] RECIP_W = 32'(RECIP);
   localparam logic [31:0] NX_W    = 32'(NX);

   pbs_ctl_type ctl_in;
   pbs_ctl_type ctl_ff [STAGES];
   logic [VALUE_W-1:0] val_ff [STAGES];
   logic [RW-1:0] lrow_ff [STAGES-1];
   logic [CW-1:0] lcol_ff [3];

   logic signed [VALUE_W-1:0] x_ff, x1_ff, u_ff;
   logic signed [VALUE_W-1:0] u_clamp;
   logic signed [DIFF_W-1:0]  d_in, d_ff;
   logic signed [TU_W-1:0]    tu_in, tu_ff;
   logic signed [TX_W-1:0]    tx_in, tx_ff;
   logic [KU_W-1:0]           ku;
   logic signed [31:0]        kx;
   logic [CW-1:0]             iu_in;
   logic [WGT_W-1:0]          fu_in;
   logic [31:0]               m_in, m_ff, m4_ff;
   logic [63:0]               p_in, p_ff;
   logic [31:0]               q;
   logic [RRW-1:0]            r_in, r_ff;
   logic [RW-1:0]             row_in, row_ff;
   logic [CW-1:0]             col_ff [4];
   pbs_wgt_type               wgt_ff [4];

   // accepted beat: kind and load range check
   always_comb begin
      ctl_in.valid   = in_valid;
      ctl_in.sample  = (in_mode == MODE_SAMPLE);
      ctl_in.load_ok = (32'(in_row) <= NX_W) && (32'(in_col) <= 32'(NU));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) ctl_ff[i] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < STAGES; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // load fields travel alongside
   always_ff @(posedge clock) begin
      if (en) begin
         val_ff[0]  <= in_value;
         lrow_ff[0] <= RW'(in_row);
         lcol_ff[0] <= CW'(in_col);
         for (int i = 1; i < STAGES; i++) val_ff[i] <= val_ff[i-1];
         for (int i = 1; i < STAGES - 1; i++) lrow_ff[i] <= lrow_ff[i-1];
         for (int i = 1; i < 3; i++) lcol_ff[i] <= lcol_ff[i-1];
      end
   end

   // u clamp and offset from the grid origin
   always_comb begin
      if (u_ff < VALUE_W'(u_low)) begin
         u_clamp = VALUE_W'(u_low);
      end else if (u_ff > VALUE_W'(u_high)) begin
         u_clamp = VALUE_W'(u_high);
      end else begin
         u_clamp = u_ff;
      end
      d_in = DIFF_W'(u_clamp - VALUE_W'(u_low));
   end

   // scale both coordinates to cell units, q27.32 for u and q32.32 for x
   always_comb begin
      tu_in = d_ff * $signed({1'b0, inv_du});
      tx_in = x1_ff * $signed({1'b0, inv_dx});
   end

   // u cell index and fraction, x index lifted for the modulo
   always_comb begin
      ku = tu_ff[TU_W-1:32];
      kx = tu_ff[TU_W-1] ? 32'sd0 : 32'sd0;
      kx = tx_ff[TX_W-1:32];
      if (tu_ff[TU_W-1]) begin
         iu_in = '0;
         fu_in = '0;
      end else if (ku > KU_W'(NU - 1)) begin
         // clamped top edge: last cell at full weight
         iu_in = CW'(NU - 1);
         fu_in = ONE_Q16;
      end else begin
         iu_in = CW'(ku);
         fu_in = {1'b0, tu_ff[31:16]};
      end
      m_in = 32'(64'(kx) + XOFFS);
   end

   // reciprocal multiply, then remainder below twice NX
   always_comb begin
      p_in = m_ff * RECIP_W;
      q    = p_ff[63:32];
      r_in = RRW'(m4_ff - q * NX_W);
   end

   // final correction of the wrapped x index
   always_comb begin
      if (r_ff >= RRW'(NX)) begin
         row_in = RW'(r_ff - RRW'(NX));
      end else begin
         row_in = RW'(r_ff);
      end
      if (!ctl_ff[5].sample) row_in = lrow_ff[STAGES-2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= in_x;
         u_ff  <= in_u;
         d_ff  <= d_in;
         x1_ff <= x_ff;
         tu_ff <= tu_in;
         tx_ff <= tx_in;
         m_ff  <= m_in;
         col_ff[0]    <= ctl_ff[2].sample ? iu_in : lcol_ff[2];
         wgt_ff[0].fu <= fu_in;
         wgt_ff[0].fx <= {1'b0, tx_ff[31:16]};
         p_ff  <= p_in;
         m4_ff <= m_ff;
         r_ff  <= r_in;
         row_ff <= row_in;
         for (int i = 1; i < 4; i++) begin
            col_ff[i] <= col_ff[i-1];
            wgt_ff[i] <= wgt_ff[i-1];
         end
      end
   end

   assign out_ctl   = ctl_ff[STAGES-1];
   assign out_row   = row_ff;
   assign out_col   = col_ff[3];
   assign out_value = val_ff[STAGES-1];
   assign out_wgt   = wgt_ff[3];

   // wrapped and capped indices stay inside the grid
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid && out_ctl.sample |-> out_row < RW'(NX))
      else $error("x cell index out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid && out_ctl.sample |-> out_col < CW'(NU) && out_wgt.fu <= ONE_Q16)
      else $error("u cell index or weight out of range");

endmodule

@@ src/pbs_grid.sv @@
`timescale 1ns / 1ps
module pbs_grid #(
   parameter int NX = 128,
   parameter int NU = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  pbs_pkg::pbs_ctl_type               in_ctl,
   input  logic [$clog2(NX+1)-1:0]            in_row,
   input  logic [$clog2(NU+1)-1:0]            in_col,
   input  logic [pbs_pkg::VALUE_W-1:0]        in_value,
   input  pbs_pkg::pbs_wgt_type               in_wgt,
   output pbs_pkg::pbs_ctl_type               out_ctl,
   output logic signed [pbs_pkg::VALUE_W-1:0] out_corner [pbs_pkg::BANKS],
   output pbs_pkg::pbs_wgt_type               out_wgt
);
   import pbs_pkg::*;

   localparam int RW    = $clog2(NX + 1);
   localparam int CW    = $clog2(NU + 1);
   localparam int RH    = NX / 2 + 1;
   localparam int CH    = NU / 2 + 1;
   localparam int DEPTH = RH * CH;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [31:0] CH_W = 32'(CH);

   logic [AW-1:0]      addr_in [BANKS];
   logic [AW-1:0]      addr_ff [BANKS];
   logic               we_in   [BANKS];
   logic               we_ff   [BANKS];
   logic [VALUE_W-1:0] wdata_ff;
   logic [VALUE_W-1:0] bank_rd [BANKS];
   pbs_ctl_type        ctl_a_ff, ctl_b_ff;
   pbs_wgt_type        wgt_a_ff, wgt_b_ff;
   logic [1:0]         par_a_ff, par_b_ff;
   logic [1:0]         sel_00, sel_10, sel_01, sel_11;

   // per bank: the corner of matching parity, or the load target
   always_comb begin
      logic [1:0]  bb;
      logic [31:0] rh;
      logic [31:0] ch;
      for (int b = 0; b < BANKS; b++) begin
         bb = 2'(b);
         rh = 32'(in_row >> 1) + 32'(in_row[0] & ~bb[1]);
         ch = 32'(in_col >> 1) + 32'(in_col[0] & ~bb[0]);
         addr_in[b] = AW'(rh * CH_W + ch);
         we_in[b]   = in_ctl.valid && !in_ctl.sample && in_ctl.load_ok &&
                      (in_row[0] == bb[1]) && (in_col[0] == bb[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         for (int b = 0; b < BANKS; b++) we_ff[b] <= 1'b0;
      end else if (en) begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
         for (int b = 0; b < BANKS; b++) we_ff[b] <= we_in[b];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int b = 0; b < BANKS; b++) addr_ff[b] <= addr_in[b];
         wdata_ff <= in_value;
         wgt_a_ff <= in_wgt;
         wgt_b_ff <= wgt_a_ff;
         par_a_ff <= {in_row[0], in_col[0]};
         par_b_ff <= par_a_ff;
      end
   end

   // four banks, write and read in the same stage so beats stay in order
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [VALUE_W-1:0] mem [DEPTH];
      logic [VALUE_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            if (we_ff[b]) mem[addr_ff[b]] <= wdata_ff;
            rd_ff <= mem[addr_ff[b]];
         end
      end

      assign bank_rd[b] = rd_ff;
   end

   // route bank data back to corner order
   always_comb begin
      sel_00 = par_b_ff;
      sel_10 = {~par_b_ff[1], par_b_ff[0]};
      sel_01 = {par_b_ff[1], ~par_b_ff[0]};
      sel_11 = ~par_b_ff;
      out_corner[CORNER_00] = $signed(bank_rd[sel_00]);
      out_corner[CORNER_10] = $signed(bank_rd[sel_10]);
      out_corner[CORNER_01] = $signed(bank_rd[sel_01]);
      out_corner[CORNER_11] = $signed(bank_rd[sel_11]);
   end

   assign out_ctl = ctl_b_ff;
   assign out_wgt = wgt_b_ff;

endmodule

@@ src/pbs_mix.sv @@
`timescale 1ns / 1ps
module pbs_mix (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  pbs_pkg::pbs_ctl_type               in_ctl,
   input  logic signed [pbs_pkg::VALUE_W-1:0] in_corner [pbs_pkg::BANKS],
   input  pbs_pkg::pbs_wgt_type               in_wgt,
   output logic                               out_valid,
   output logic signed [pbs_pkg::VALUE_W-1:0] out_value
);
   import pbs_pkg::*;

   logic [WGT_W-1:0]          wu0, wx0;
   logic [WGT_W-1:0]          fx_ff;
   logic signed [BLEND_W-1:0] a0_in, a1_in, a0_ff, a1_ff;
   logic signed [ACC_W-1:0]   acc_in, acc_ff;
   logic [ACC_W-1:0]          rnd;
   logic signed [RND_W-1:0]   q;
   logic signed [VALUE_W-1:0] res_in, res_ff;
   logic                      v1_ff, v2_ff, v3_ff;

   // blend along u for both rows
   always_comb begin
      wu0   = ONE_Q16 - in_wgt.fu;
      a0_in = $signed({1'b0, wu0}) * in_corner[CORNER_00]
            + $signed({1'b0, in_wgt.fu}) * in_corner[CORNER_01];
      a1_in = $signed({1'b0, wu0}) * in_corner[CORNER_10]
            + $signed({1'b0, in_wgt.fu}) * in_corner[CORNER_11];
   end

   // blend along x
   always_comb begin
      wx0    = ONE_Q16 - fx_ff;
      acc_in = $signed({1'b0, wx0}) * a0_ff + $signed({1'b0, fx_ff}) * a1_ff;
   end

   // round half up, drop 32 fraction bits, saturate
   always_comb begin
      rnd = acc_ff + ROUND_HALF;
      q   = $signed(rnd[ACC_W-1:32]);
      if (q > RES_MAX) begin
         res_in = RES_MAX[VALUE_W-1:0];
      end else if (q < RES_MIN) begin
         res_in = RES_MIN[VALUE_W-1:0];
      end else begin
         res_in = q[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_ctl.valid && in_ctl.sample;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff  <= a0_in;
         a1_ff  <= a1_in;
         fx_ff  <= in_wgt.fx;
         acc_ff <= acc_in;
         res_ff <= res_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_value = res_ff;

endmodule

@@ src/periodic_grid_bilinear_sampler.sv @@
`timescale 1ns / 1ps
// Bilinear sampler over a periodic (NX+1) x (NU+1) grid of Q16.16 values. A beat with
// mode 0 writes one grid entry (out-of-range rows or columns are dropped, no response);
// a beat with mode 1 returns one interpolated value. One beat is taken every cycle unless
// the pipeline is halted, loads and samples freely mixed. The grid sits in four
// single-port banks split by row and column parity, so the four corners of any cell are
// read in the same cycle; loads and reads use the same pipeline stage, so a sample always
// sees every load taken before it. The pipeline only halts when a finished response is
// waiting on rsp_ready and the next one has reached the last stage. There is no clearing
// pass after reset: sampling a cell whose entries were never loaded returns an undefined
// value. Rows addressable by a load are limited to 0..255 by the width of req_load_row.
// Configuration registers may only be written while idle.
module periodic_grid_bilinear_sampler #(
   parameter int NX = 128,
   parameter int NU = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pbs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pbs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [pbs_pkg::ROW_W-1:0]           req_load_row,
   input  logic [pbs_pkg::COL_W-1:0]           req_load_col,
   input  logic signed [pbs_pkg::VALUE_W-1:0]  req_load_value,
   input  logic signed [pbs_pkg::VALUE_W-1:0]  req_sample_x,
   input  logic signed [pbs_pkg::VALUE_W-1:0]  req_sample_u,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pbs_pkg::VALUE_W-1:0]  rsp_sampled_value
);
   import pbs_pkg::*;

   localparam int RW = $clog2(NX + 1);
   localparam int CW = $clog2(NU + 1);

   logic signed [ULIM_W-1:0] u_low_ff, u_high_ff;
   logic [INV_W-1:0]         inv_dx_ff, inv_du_ff;
   logic                     en, stall, accept;

   pbs_ctl_type        crd_ctl, grd_ctl;
   logic [RW-1:0]      crd_row;
   logic [CW-1:0]      crd_col;
   logic [VALUE_W-1:0] crd_value;
   pbs_wgt_type        crd_wgt, grd_wgt;
   logic signed [VALUE_W-1:0] grd_corner [BANKS];
   logic                      mix_valid;
   logic signed [VALUE_W-1:0] mix_value;

   logic                      out_valid_in, out_valid_ff;
   logic signed [VALUE_W-1:0] out_value_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         u_low_ff  <= U_LOW_RST;
         u_high_ff <= U_HIGH_RST;
         inv_dx_ff <= INV_DX_RST;
         inv_du_ff <= INV_DU_RST;
      end else if (csr_we) begin
         case (pbs_csr_type'(csr_index))
            CSR_U_LOW:  u_low_ff  <= $signed(csr_wdata[ULIM_W-1:0]);
            CSR_U_HIGH: u_high_ff <= $signed(csr_wdata[ULIM_W-1:0]);
            CSR_INV_DX: inv_dx_ff <= csr_wdata[INV_W-1:0];
            CSR_INV_DU: inv_du_ff <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline halts only when a response is blocked behind a waiting one
   assign stall     = mix_valid && out_valid_ff && !rsp_ready;
   assign en        = !stall;
   assign req_ready = en;
   assign accept    = req_valid && en;

   pbs_coord #(.NX(NX), .NU(NU)) u_coord (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .in_mode   (req_mode),
      .in_row    (req_load_row),
      .in_col    (req_load_col),
      .in_value  (req_load_value),
      .in_x      (req_sample_x),
      .in_u      (req_sample_u),
      .u_low     (u_low_ff),
      .u_high    (u_high_ff),
      .inv_dx    (inv_dx_ff),
      .inv_du    (inv_du_ff),
      .out_ctl   (crd_ctl),
      .out_row   (crd_row),
      .out_col   (crd_col),
      .out_value (crd_value),
      .out_wgt   (crd_wgt)
   );

   pbs_grid #(.NX(NX), .NU(NU)) u_grid (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_ctl     (crd_ctl),
      .in_row     (crd_row),
      .in_col     (crd_col),
      .in_value   (crd_value),
      .in_wgt     (crd_wgt),
      .out_ctl    (grd_ctl),
      .out_corner (grd_corner),
      .out_wgt    (grd_wgt)
   );

   pbs_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (grd_ctl),
      .in_corner (grd_corner),
      .in_wgt    (grd_wgt),
      .out_valid (mix_valid),
      .out_value (mix_value)
   );

   // response register
   always_comb begin
      if (en && mix_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && mix_valid) out_value_ff <= mix_value;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sampled_value = out_value_ff;

   // a halted pipeline keeps its last stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(mix_value) && mix_valid)
      else $error("last stage changed while halted");

   // a finished sample lands in the response register
   a_rsp_capture: assert property (@(posedge clock) disable iff (reset)
      en && mix_valid |=> rsp_valid && (rsp_sampled_value == $past(mix_value)))
      else $error("response not captured");

endmodule

@@ tb/periodic_grid_bilinear_sampler_tb.sv @@
`timescale 1ns / 1ps
module periodic_grid_bilinear_sampler_tb;
   import pbs_pkg::*;

   localparam int GRID_NX = 128;
   localparam int GRID_NU = 256;
   localparam logic MODE_LOAD = ~MODE_SAMPLE;
   localparam int DRAIN_CYCLES = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef struct {
      logic mode;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic signed [31:0] value;
      logic signed [31:0] sx;
      logic signed [31:0] su;
      int unsigned gap;
   } grid_beat_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   logic req_mode;
   logic [ROW_W-1:0] req_load_row;
   logic [COL_W-1:0] req_load_col;
   logic signed [31:0] req_load_value;
   logic signed [31:0] req_sample_x;
   logic signed [31:0] req_sample_u;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_sampled_value;

   // beats waiting to be driven and values still owed by the block
   grid_beat_t pending_beats[$];
   logic signed [31:0] expected_values[$];

   // mirror of the grid and the registers
   logic signed [31:0] grid_mirror[0:GRID_NX][0:GRID_NU];
   logic signed [ULIM_W-1:0] lim_lo;
   logic signed [ULIM_W-1:0] lim_hi;
   logic [INV_W-1:0] scale_x;
   logic [INV_W-1:0] scale_u;

   logic req_taken;
   logic rsp_taken;
   int unsigned gap_count;
   int unsigned rsp_hold;
   int unsigned result_count;
   int unsigned quiet_cycles;
   int unsigned fail_count;
   bit stim_calm;
   bit rsp_calm;

   periodic_grid_bilinear_sampler #(
      .NX(GRID_NX),
      .NU(GRID_NU)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_load_row(req_load_row),
      .req_load_col(req_load_col),
      .req_load_value(req_load_value),
      .req_sample_x(req_sample_x),
      .req_sample_u(req_sample_u),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sampled_value(rsp_sampled_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // weight times corner, wide enough for the full convex sum
   function automatic logic signed [67:0] corner_term(longint w, logic signed [31:0] c);
      logic signed [67:0] wa;
      logic signed [67:0] ca;
      wa = w;
      ca = c;
      return wa * ca;
   endfunction

   // bilinear value at (x, u) under the current register settings
   function automatic logic signed [31:0] interp_value(logic signed [31:0] x,
                                                       logic signed [31:0] u);
      longint lo, hi, uc, tu, tx, kx, iu, fu, fx;
      logic signed [67:0] acc;
      lo = longint'(lim_lo);
      hi = longint'(lim_hi);
      uc = longint'(u);
      if (uc < lo) begin
         uc = lo;
      end else if (uc > hi) begin
         uc = hi;
      end
      tu = (uc - lo) * longint'(scale_u);
      // inverted limits give a negative offset, top edge pins the fraction at one
      if (tu < 0) begin
         iu = 0;
         fu = 0;
      end else if ((tu >>> 32) > GRID_NU - 1) begin
         iu = GRID_NU - 1;
         fu = 65536;
      end else begin
         iu = tu >>> 32;
         fu = (tu >>> 16) & 64'hFFFF;
      end
      // periodic in x
      tx = longint'(x) * longint'(scale_x);
      kx = (tx >>> 32) % GRID_NX;
      if (kx < 0) begin
         kx = kx + GRID_NX;
      end
      fx = (tx >>> 16) & 64'hFFFF;
      acc = corner_term((65536 - fx) * (65536 - fu), grid_mirror[kx][iu]);
      acc = acc + corner_term(fx * (65536 - fu), grid_mirror[kx + 1][iu]);
      acc = acc + corner_term((65536 - fx) * fu, grid_mirror[kx][iu + 1]);
      acc = acc + corner_term(fx * fu, grid_mirror[kx + 1][iu + 1]);
      acc = (acc + 68'sd2147483648) >>> 32;
      if (acc > 68'sd2147483647) begin
         acc = 68'sd2147483647;
      end else if (acc < -68'sd2147483648) begin
         acc = -68'sd2147483648;
      end
      return acc[31:0];
   endfunction

   function automatic int unsigned next_gap();
      return stim_calm ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic push_load(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic signed [31:0] value, int unsigned gap);
      grid_beat_t b;
      b.mode = MODE_LOAD;
      b.row = row;
      b.col = col;
      b.value = value;
      b.sx = $urandom;
      b.su = $urandom;
      b.gap = gap;
      pending_beats.push_back(b);
   endtask

   task automatic push_sample(logic signed [31:0] x, logic signed [31:0] u);
      grid_beat_t b;
      b.mode = MODE_SAMPLE;
      b.row = $urandom;
      b.col = $urandom;
      b.value = $urandom;
      b.sx = x;
      b.su = u;
      b.gap = next_gap();
      pending_beats.push_back(b);
   endtask

   // one register write per falling edge, the enable is lowered by the caller
   task automatic set_reg(pbs_csr_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_U_LOW: lim_lo = data[ULIM_W-1:0];
         CSR_U_HIGH: lim_hi = data[ULIM_W-1:0];
         CSR_INV_DX: scale_x = data[INV_W-1:0];
         CSR_INV_DU: scale_u = data[INV_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(logic [ULIM_W-1:0] lo, logic [ULIM_W-1:0] hi,
                               logic [INV_W-1:0] sx, logic [INV_W-1:0] su);
      set_reg(CSR_U_LOW, {6'($urandom), lo});
      set_reg(CSR_U_HIGH, {6'($urandom), hi});
      set_reg(CSR_INV_DX, sx);
      set_reg(CSR_INV_DU, su);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (!(pending_beats.size() == 0 && !req_valid && expected_values.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mixed loads and samples, u biased towards the clamp bounds and the span between
   task automatic run_random(int n);
      int lo_i;
      int hi_i;
      logic signed [31:0] x;
      logic signed [31:0] u;
      lo_i = lim_lo;
      hi_i = lim_hi;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            stim_calm = ($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3: push_load($urandom_range(0, GRID_NX), $urandom_range(0, GRID_NU),
                                  $urandom, next_gap());
            4: push_load($urandom, $urandom, $urandom, next_gap());
            default: begin
               if ($urandom_range(0, 1) == 0) begin
                  x = $urandom;
               end else begin
                  x = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
               end
               case ($urandom_range(0, 5))
                  0: u = $urandom;
                  1: u = lo_i;
                  2: u = hi_i;
                  default: begin
                     if (hi_i >= lo_i) begin
                        u = lo_i + int'($urandom_range(0, hi_i - lo_i));
                     end else begin
                        u = hi_i + int'($urandom_range(0, lo_i - hi_i));
                     end
                  end
               endcase
               push_sample(x, u);
            end
         endcase
      end
      stim_calm = 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      grid_beat_t b;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count <= 0;
      end else if (!req_valid || req_taken) begin
         if (pending_beats.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gap_count < pending_beats[0].gap) begin
            req_valid <= 1'b0;
            gap_count <= gap_count + 1;
         end else begin
            b = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_mode <= b.mode;
            req_load_row <= b.row;
            req_load_col <= b.col;
            req_load_value <= b.value;
            req_sample_x <= b.sx;
            req_sample_u <= b.su;
            gap_count <= 0;
         end
      end
   end

   // response back-pressure, drawn per beat
   always @(negedge clock) begin : drive_rsp_ready
      int unsigned hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_taken) begin
         hold = rsp_calm ? 0 : $urandom_range(0, 8);
         rsp_ready <= (hold == 0);
         rsp_hold <= hold;
      end else if (rsp_hold > 0) begin
         rsp_ready <= (rsp_hold == 1);
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check responses first, then take in the accepted request
   always @(posedge clock) begin : monitor
      logic signed [31:0] want;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            $error("sampled_value with nothing expected: got %0d", rsp_sampled_value);
            fail_count++;
         end else begin
            want = expected_values.pop_front();
            if (rsp_sampled_value !== want) begin
               $error("sampled_value mismatch: expected %0d, got %0d", want,
                      rsp_sampled_value);
               fail_count++;
            end
         end
         result_count++;
         if (result_count % 32 == 0) begin
            rsp_calm <= ($urandom_range(0, 3) == 0);
         end
      end
      if (!reset && req_valid && req_ready) begin
         if (req_mode == MODE_SAMPLE) begin
            expected_values.push_back(interp_value(req_sample_x, req_sample_u));
         end else if (req_load_row <= GRID_NX && req_load_col <= GRID_NU) begin
            grid_mirror[req_load_row][req_load_col] = req_load_value;
         end
      end
   end

   // cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("periodic_grid_bilinear_sampler_tb failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_U_LOW;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_mode = MODE_LOAD;
      req_load_row = '0;
      req_load_col = '0;
      req_load_value = '0;
      req_sample_x = '0;
      req_sample_u = '0;
      rsp_ready = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      result_count = 0;
      quiet_cycles = 0;
      fail_count = 0;
      stim_calm = 1'b0;
      rsp_calm = 1'b0;
      lim_lo = U_LOW_RST;
      lim_hi = U_HIGH_RST;
      scale_x = INV_DX_RST;
      scale_u = INV_DU_RST;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every entry so no sample touches an unwritten one
      for (int r = 0; r <= GRID_NX; r++)
         for (int c = 0; c <= GRID_NU; c++)
            push_load(r, c, $urandom, 0);

      // directed: saturated corners, clamps, wrap to the last row, dropped loads
      for (int k = 0; k < 4; k++)
         push_load(k / 2, k % 2, VAL_MAX, next_gap());
      push_sample(32'sd3000, U_LOW_RST + 1000);
      push_sample(32'sd0, VAL_MIN);
      for (int k = 0; k < 4; k++)
         push_load(k / 2, k % 2, VAL_MIN, next_gap());
      push_sample(32'sd3000, U_LOW_RST + 1000);
      push_load(GRID_NX, GRID_NU, VAL_MIN, next_gap());
      push_sample(-32'sd1, VAL_MAX);
      push_sample(VAL_MAX, U_HIGH_RST);
      push_sample(VAL_MIN, U_LOW_RST);
      push_load(GRID_NX + 1, 0, VAL_MAX, next_gap());
      push_load(0, GRID_NU + 1, VAL_MAX, next_gap());
      push_load(8'hFF, 9'h1FF, VAL_MAX, next_gap());
      push_sample(32'sd0, U_LOW_RST);
      push_sample(32'sd0, 32'sd0);
      wait_drained();

      // nominal limits, u scale just past the top edge
      program_regs(-25'sd393216, 25'sd393216, 31'd667544, 31'd1398102);
      run_random(140);
      wait_drained();

      // widest limits, smallest scales
      program_regs(25'h100_0000, 25'h0FF_FFFF, 31'd1, 31'd1);
      run_random(140);
      wait_drained();

      // narrow span, largest scales
      program_regs(25'd0, 25'd65536, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      run_random(140);
      wait_drained();

      // inverted limits
      program_regs(25'sd196608, -25'sd196608, 31'd65536, 31'd131072);
      run_random(140);
      wait_drained();

      // random limits in order, random scales
      begin
         logic [ULIM_W-1:0] a;
         logic [ULIM_W-1:0] b;
         a = $urandom;
         b = $urandom;
         if ($signed(a) > $signed(b)) begin
            program_regs(b, a, $urandom_range(1, 32'h0100_0000), $urandom);
         end else begin
            program_regs(a, b, $urandom_range(1, 32'h0100_0000), $urandom);
         end
      end
      run_random(140);
      wait_drained();

      // fully random register contents
      program_regs($urandom, $urandom, $urandom, $urandom_range(1, 32'h0004_0000));
      run_random(140);
      wait_drained();

      if (fail_count == 0 && expected_values.size() == 0) begin
         $display("periodic_grid_bilinear_sampler_tb passed");
      end else begin
         $display("periodic_grid_bilinear_sampler_tb failed");
      end
      $finish;
   end

endmodule
